// ===== design/sensor_stream_min_max_moving_average_assert.svh =====
// Assertion macros shared by the checker of the sensor statistics block.
// Depends on nothing; included by the checker file.
`ifndef SENSOR_STREAM_MIN_MAX_MOVING_AVERAGE_ASSERT_SVH
`define SENSOR_STREAM_MIN_MAX_MOVING_AVERAGE_ASSERT_SVH

// Generic concurrent check, disabled while reset is asserted.
`define SSMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssmm assertion failed");

// A stalled word keeps its payload until it is taken.
`define SSMM_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> $stable(sig)) \
    else $error("ssmm stalled word changed");

`endif

// ===== design/ssmm_pkg.sv =====
// Shared constants and helpers for the sensor min/max/moving-average block.
// No dependencies; imported by all modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package ssmm_pkg;

  localparam int NUM_CH               = 3;
  localparam int DEFAULT_WINDOW_LEN   = 16;
  localparam int DEFAULT_SAMPLE_WIDTH = 16;

  // Stream data width: bits rounded up to whole bytes.
  function automatic int tdata_w(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

  function automatic bit is_pow2(input int n);
    return (n & (n - 1)) == 0;
  endfunction

endpackage

`default_nettype wire

// ===== design/sensor_stream_min_max_moving_average.sv =====
// Each result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the whole pipeline halts while a result stalls.
// The window length must be a power of two so the average is a single shift.
// Reset: asynchronous, active low; clears sums, extremes and write position.
// The window memories are not cleared: a wrap flag reads unwritten entries as zero.
`timescale 1ns / 1ps
`default_nettype none

module sensor_stream_min_max_moving_average
  import ssmm_pkg::*;
#(
  parameter int WINDOW_LEN   = DEFAULT_WINDOW_LEN,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
  localparam int InW  = tdata_w(NUM_CH * SAMPLE_WIDTH),
  localparam int OutW = tdata_w(3 * NUM_CH * SAMPLE_WIDTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // temperature_sample, soc_sample, charge_rate_sample
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // min_temperature, max_temperature, min_soc, max_soc, min_charge_rate,
  // max_charge_rate, avg_temperature, avg_soc, avg_charge_rate
  output logic [OutW-1:0] m_axis_tdata
);

  localparam int SumW  = SAMPLE_WIDTH + $clog2(WINDOW_LEN);
  localparam int PosW  = $clog2(WINDOW_LEN);
  localparam int PassW = 2 * NUM_CH * SAMPLE_WIDTH;
  localparam logic [SAMPLE_WIDTH-1:0] SampleMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SampleMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_LEN - 1);

  logic                    en;
  logic                    accept;
  logic [PosW-1:0]         pos_q, pos_d;
  logic                    wrapped_q;
  logic [SumW-1:0]         sum_w [NUM_CH];
  logic [PassW-1:0]        pass_w;
  logic                    div_valid;
  logic [SAMPLE_WIDTH-1:0] div_avg [NUM_CH];
  logic [PassW-1:0]        div_pass;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wrapped_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (accept && pos_q == LastPos) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [SAMPLE_WIDTH-1:0] win_mem [WINDOW_LEN];
    logic [SAMPLE_WIDTH-1:0] rd_q;
    logic [SAMPLE_WIDTH-1:0] x;
    logic [SAMPLE_WIDTH-1:0] old;
    logic [SumW-1:0]         sum_q, sum_d;
    logic [SAMPLE_WIDTH-1:0] min_q, min_d, max_q, max_d;

    assign x     = s_axis_tdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    // Entries not yet written since reset count as zero.
    assign old   = wrapped_q ? rd_q : '0;
    assign sum_d = sum_q - SumW'($signed(old)) + SumW'($signed(x));
    assign min_d = ($signed(x) < $signed(min_q)) ? x : min_q;
    assign max_d = ($signed(x) > $signed(max_q)) ? x : max_q;

    // Prefetch the entry the next word replaces; it never equals the write slot.
    always_ff @(posedge clk_i) begin
      if (accept) begin
        win_mem[pos_q] <= x;
      end
      rd_q <= win_mem[pos_d];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sum_q <= '0;
        min_q <= SampleMax;
        max_q <= SampleMin;
      end else if (accept) begin
        sum_q <= sum_d;
        min_q <= min_d;
        max_q <= max_d;
      end
    end

    assign sum_w[c] = sum_d;
    assign pass_w[2*c*SAMPLE_WIDTH     +: SAMPLE_WIDTH] = min_d;
    assign pass_w[(2*c+1)*SAMPLE_WIDTH +: SAMPLE_WIDTH] = max_d;
  end

  ssmm_avg_div #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .PASS_W      (PassW)
  ) u_avg_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(accept),
    .sum_i  (sum_w),
    .pass_i (pass_w),
    .valid_o(div_valid),
    .avg_o  (div_avg),
    .pass_o (div_pass)
  );

  assign m_axis_tvalid = div_valid;
  assign m_axis_tdata  = OutW'({div_avg[2], div_avg[1], div_avg[0], div_pass});

endmodule

`default_nettype wire

// ===== design/ssmm_avg_div.sv =====
// Floor division of the three window sums by a power-of-two window length.
// One register stage: each sum is shifted right arithmetically, min/max words ride along.
// Uses ssmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssmm_avg_div
  import ssmm_pkg::*;
#(
  parameter int WINDOW_LEN   = DEFAULT_WINDOW_LEN,
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
  parameter int PASS_W       = 2 * NUM_CH * DEFAULT_SAMPLE_WIDTH
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            valid_i,
  input  logic [SAMPLE_WIDTH+$clog2(WINDOW_LEN)-1:0]      sum_i [NUM_CH],
  input  logic [PASS_W-1:0]                               pass_i,
  output logic                                            valid_o,
  output logic [SAMPLE_WIDTH-1:0]                         avg_o [NUM_CH],
  output logic [PASS_W-1:0]                               pass_o
);

  localparam int SumW    = SAMPLE_WIDTH + $clog2(WINDOW_LEN);
  localparam int Log2Len = $clog2(WINDOW_LEN);

  logic                    valid_q;
  logic [SAMPLE_WIDTH-1:0] avg_q [NUM_CH];
  logic [PASS_W-1:0]       pass_q;

  // Only a power-of-two window divides by a plain shift.
  if (!is_pow2(WINDOW_LEN)) begin : g_len_check
    $error("ssmm_avg_div: WINDOW_LEN must be a power of two");
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Drop the low bits: an arithmetic shift rounds toward minus infinity.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_q <= pass_i;
      for (int c = 0; c < NUM_CH; c++) begin
        avg_q[c] <= sum_i[c][SumW-1:Log2Len];
      end
    end
  end

  assign valid_o = valid_q;
  assign avg_o   = avg_q;
  assign pass_o  = pass_q;

endmodule

`default_nettype wire

// ===== design/ssmm_checker.sv =====
// Port-level checks for the sensor min/max/moving-average block, bound to the top.
// Depends on ssmm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_stream_min_max_moving_average_assert.svh"

module ssmm_checker
  import ssmm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH,
  localparam int OutW = tdata_w(3 * NUM_CH * SAMPLE_WIDTH)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  localparam int Sw = SAMPLE_WIDTH;

  logic signed [Sw-1:0] min_t, max_t, min_s, max_s, min_r, max_r;
  logic                 min_le_max;

  assign min_t      = m_axis_tdata[0*Sw +: Sw];
  assign max_t      = m_axis_tdata[1*Sw +: Sw];
  assign min_s      = m_axis_tdata[2*Sw +: Sw];
  assign max_s      = m_axis_tdata[3*Sw +: Sw];
  assign min_r      = m_axis_tdata[4*Sw +: Sw];
  assign max_r      = m_axis_tdata[5*Sw +: Sw];
  assign min_le_max = (min_t <= max_t) && (min_s <= max_s) && (min_r <= max_r);

  `SSMM_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)

  // Input side only backs off while a result word is stuck.
  `SSMM_ASSERT(a_ready_stall, clk_i, rst_ni, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))

  `SSMM_ASSERT(a_min_le_max, clk_i, rst_ni, m_axis_tvalid |-> min_le_max)

  // An accepted word shows up as a result on the next cycle.
  `SSMM_ASSERT(a_in_to_out, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)

endmodule

bind sensor_stream_min_max_moving_average ssmm_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ssmm_checker (.*);

`default_nettype wire

// ===== tb/sv/sensor_stream_min_max_moving_average_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the sensor min/max/moving-average stream block.
// Depends on ssmm_pkg and the block itself; every result word is checked
// against a cycle-free model of the running extremes and window sums.

module sensor_stream_min_max_moving_average_test;
  import ssmm_pkg::*;

  localparam int SW   = DEFAULT_SAMPLE_WIDTH;
  localparam int WIN  = DEFAULT_WINDOW_LEN;
  localparam int InW  = tdata_w(NUM_CH * SW);
  localparam int OutW = tdata_w(3 * NUM_CH * SW);

  localparam int ITEMS_PER_PHASE = 400;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 2 * SW + 4;

  typedef logic signed [SW-1:0] sample_t;

  // Listed from the top down, so the last field lands in the lowest bits.
  typedef struct packed {
    sample_t charge_rate;
    sample_t soc;
    sample_t temperature;
  } sample_set_t;

  typedef struct packed {
    sample_t avg_charge_rate;
    sample_t avg_soc;
    sample_t avg_temperature;
    sample_t max_charge_rate;
    sample_t min_charge_rate;
    sample_t max_soc;
    sample_t min_soc;
    sample_t max_temperature;
    sample_t min_temperature;
  } stats_t;

  typedef struct {
    sample_set_t samples;
    bit          typed;
    stats_t      want;
  } directed_row_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // temperature_sample, soc_sample, charge_rate_sample
  logic [InW-1:0]   s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // min_temperature, max_temperature, min_soc, max_soc, min_charge_rate,
  // max_charge_rate, avg_temperature, avg_soc, avg_charge_rate
  logic [OutW-1:0]  m_axis_tdata;

  sensor_stream_min_max_moving_average #(
    .WINDOW_LEN  (WIN),
    .SAMPLE_WIDTH(SW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Window model state.
  sample_t window_mem [NUM_CH][WIN];
  int      window_sum [NUM_CH];
  sample_t lowest     [NUM_CH];
  sample_t highest    [NUM_CH];
  int      slot;

  stats_t        expected_stats[$];
  directed_row_t directed_rows[$];
  int            error_count = 0;
  int            result_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_results = 1'b0;

  task automatic clear_window_model();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int i = 0; i < WIN; i++) window_mem[ch][i] = '0;
      window_sum[ch] = 0;
      lowest[ch]     = S_MAX;
      highest[ch]    = S_MIN;
    end
    slot = 0;
  endtask

  function automatic stats_t advance_stats(input sample_set_t in);
    sample_t x[NUM_CH];
    sample_t avg[NUM_CH];
    stats_t  r;
    int      q;
    x[0] = in.temperature;
    x[1] = in.soc;
    x[2] = in.charge_rate;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (x[ch] < lowest[ch]) lowest[ch] = x[ch];
      if (x[ch] > highest[ch]) highest[ch] = x[ch];
      window_sum[ch] = window_sum[ch] - int'(window_mem[ch][slot]) + int'(x[ch]);
      window_mem[ch][slot] = x[ch];
      // floor division: round toward minus infinity
      q = window_sum[ch] / WIN;
      if ((window_sum[ch] % WIN) != 0 && window_sum[ch] < 0) q = q - 1;
      avg[ch] = sample_t'(q);
    end
    slot = (slot == WIN - 1) ? 0 : slot + 1;
    r.min_temperature = lowest[0];
    r.max_temperature = highest[0];
    r.min_soc         = lowest[1];
    r.max_soc         = highest[1];
    r.min_charge_rate = lowest[2];
    r.max_charge_rate = highest[2];
    r.avg_temperature = avg[0];
    r.avg_soc         = avg[1];
    r.avg_charge_rate = avg[2];
    return r;
  endfunction

  function automatic stats_t make_stats(input sample_t min_t, max_t, min_s, max_s,
                                        min_c, max_c, avg_t, avg_s, avg_c);
    stats_t r;
    r.min_temperature = min_t;
    r.max_temperature = max_t;
    r.min_soc         = min_s;
    r.max_soc         = max_s;
    r.min_charge_rate = min_c;
    r.max_charge_rate = max_c;
    r.avg_temperature = avg_t;
    r.avg_soc         = avg_s;
    r.avg_charge_rate = avg_c;
    return r;
  endfunction

  task automatic add_row(input sample_t t, s, c, input bit typed, input stats_t want);
    directed_row_t row;
    row.samples.temperature = t;
    row.samples.soc         = s;
    row.samples.charge_rate = c;
    row.typed               = typed;
    row.want                = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: return S_MAX;
        1: return S_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    // slow sensor-like values close to zero
    if (pick <= 3) return sample_t'(int'($urandom_range(1023)) - 512);
    return sample_t'($urandom);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input sample_t got, input sample_t want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_count, name, got, want));
  endtask

  task automatic take_result(input stats_t got);
    stats_t want;
    if (expected_stats.size() == 0) begin
      report_mismatch($sformatf("result word %0d arrived with nothing pending",
                                result_count));
    end else begin
      want = expected_stats.pop_front();
      check_field("min_temperature", got.min_temperature, want.min_temperature);
      check_field("max_temperature", got.max_temperature, want.max_temperature);
      check_field("min_soc",         got.min_soc,         want.min_soc);
      check_field("max_soc",         got.max_soc,         want.max_soc);
      check_field("min_charge_rate", got.min_charge_rate, want.min_charge_rate);
      check_field("max_charge_rate", got.max_charge_rate, want.max_charge_rate);
      check_field("avg_temperature", got.avg_temperature, want.avg_temperature);
      check_field("avg_soc",         got.avg_soc,         want.avg_soc);
      check_field("avg_charge_rate", got.avg_charge_rate, want.avg_charge_rate);
    end
    result_count++;
  endtask

  // Offer one word, wait for the handshake, then queue what it must produce.
  task automatic send_samples(input sample_set_t item, input bit typed,
                              input stats_t typed_want);
    stats_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InW'(item);
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_stats(item);
    if (typed) predicted = typed_want;
    expected_stats.insert(expected_stats.size(), predicted);
  endtask

  // Result side: random backpressure, plus one long hold on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) take_result(stats_t'(m_axis_tdata));
    end
  end

  initial begin
    sample_set_t item;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    clear_window_model();

    // Extremes right after reset; both first results read straight off.
    add_row(S_MAX, S_MIN, 0, 1'b1,
            make_stats(S_MAX, S_MAX, S_MIN, S_MIN, 0, 0, 2047, -2048, 0));
    add_row(S_MIN, S_MAX, -1, 1'b1,
            make_stats(S_MIN, S_MAX, S_MIN, S_MAX, -1, 0, -1, -1, -1));
    // Fill the whole window past the ring wrap: largest sums, no overflow.
    for (int i = 0; i < WIN - 1; i++) add_row(S_MAX, S_MIN, S_MAX, 1'b0, '0);
    add_row(S_MAX, S_MIN, S_MAX, 1'b1,
            make_stats(S_MIN, S_MAX, S_MIN, S_MAX, -1, S_MAX, S_MAX, S_MIN, S_MAX));
    // Negative sums that are not multiples of the window length, bit patterns.
    add_row(-1, -1, -1, 1'b0, '0);
    add_row(16, -16, 1, 1'b0, '0);
    add_row(-17, 17, -15, 1'b0, '0);
    add_row(256, -256, 128, 1'b0, '0);
    add_row(sample_t'(16'h5555), sample_t'(16'haaaa), 0, 1'b0, '0);
    add_row(S_MIN, S_MIN, S_MIN, 1'b0, '0);
    add_row(S_MAX, S_MAX, S_MAX, 1'b0, '0);

    send_idle_pct = 30;
    recv_idle_pct = 63;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_samples(directed_rows[i].samples, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 30 : 0;
      // hold the result side long enough to back up into the input
      if (phase == 2) hold_results = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        item.temperature = rand_sample();
        item.soc         = rand_sample();
        item.charge_rate = rand_sample();
        send_samples(item, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
